### src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared widths and constants for the percentile rank block.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int FRAC_BITS       = 16;
    localparam int RANK_W          = FRAC_BITS + 1;
    localparam int MAX_SAMPLES_DEF = 64;

    localparam logic [RANK_W-1:0] RANK_HALF = RANK_W'(1) << (FRAC_BITS - 1);
    localparam logic [RANK_W-1:0] RANK_ONE  = RANK_W'(1) << FRAC_BITS;

endpackage

`default_nettype wire

### src/percentile_rank_ties_averaged.sv
// ----------------------------------------------------------------------------
// percentile_rank_ties_averaged
// Percentile rank with ties averaged over one cross-section of samples.
// ----------------------------------------------------------------------------
// Each accepted word stores one sample while the store has room; a word that
// finds it full sets capacity_overflow. The word marked last_sample starts
// the ranking run: busy stays high until every stored sample has produced its
// result, in arrival order, each shown for exactly one cycle with result_valid;
// the receiver cannot stall, so results must be taken as they come. A finite
// sample is fetched, then the store is scanned through its single read
// port, then the shared bit-serial divider ranks it before it is emitted.
// A missing sample, or the only finite one, skips the scan and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module percentile_rank_ties_averaged #(
    parameter int MAX_SAMPLES = prt_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [prt_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                                sample_finite,
    input  wire logic                                last_sample,
    output logic                                     result_valid,
    output logic [prt_pkg::RANK_W-1:0]               rank_fraction,
    output logic                                     missing_sample,
    output logic                                     capacity_overflow,
    output logic                                     last_result
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int DW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADV = 3'd1;
    localparam logic [2:0] S_GETV  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic signed [prt_pkg::SAMPLE_W-1:0] val_mem [MAX_SAMPLES];
    logic                                fin_mem [MAX_SAMPLES];

    logic [2:0]                          state_reg;
    logic [CW-1:0]                       loaded_reg;
    logic [CW-1:0]                       valid_reg;
    logic                                ovf_reg;
    logic [IW-1:0]                       idx_reg;
    logic [CW-1:0]                       scan_reg;
    logic                                pend_reg;
    logic [CW-1:0]                       less_reg;
    logic [CW-1:0]                       eq_reg;
    logic signed [prt_pkg::SAMPLE_W-1:0] cur_reg;
    logic signed [prt_pkg::SAMPLE_W-1:0] rd_val_reg;
    logic                                rd_fin_reg;
    logic [prt_pkg::RANK_W-1:0]          rank_reg;
    logic                                miss_reg;

    logic                                accept;
    logic                                room;
    logic [IW-1:0]                       rd_addr;
    logic                                div_start;
    logic [DW-1:0]                       div_num;
    logic [DW-1:0]                       div_den;
    logic                                div_done;
    logic [prt_pkg::RANK_W-1:0]          div_q;
    logic                                is_last;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign room    = (loaded_reg < CW'(MAX_SAMPLES));
    assign rd_addr = (state_reg == S_SCAN) ? scan_reg[IW-1:0] : idx_reg;
    assign is_last = ({1'b0, idx_reg} + (IW + 1)'(1)) == (IW + 1)'(loaded_reg);

    assign div_start = (state_reg == S_DIV);
    assign div_num   = {less_reg, 1'b0} + {1'b0, eq_reg} - DW'(1);
    assign div_den   = {valid_reg, 1'b0} - DW'(2);

    prt_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            val_mem[loaded_reg[IW-1:0]] <= sample_value;
            fin_mem[loaded_reg[IW-1:0]] <= sample_finite;
        end
        rd_val_reg <= val_mem[rd_addr];
        rd_fin_reg <= fin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            loaded_reg <= '0;
            valid_reg  <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            loaded_reg <= loaded_reg + CW'(1);
                            valid_reg  <= valid_reg + CW'(sample_finite);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_sample)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_LOADV;
                        end
                    end
                end
                S_LOADV:
                begin
                    state_reg <= S_GETV;
                end
                S_GETV:
                begin
                    scan_reg <= '0;
                    pend_reg <= 1'b0;
                    if (!rd_fin_reg || valid_reg <= CW'(1))
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    pend_reg <= (scan_reg != loaded_reg);
                    if (scan_reg != loaded_reg)
                        scan_reg <= scan_reg + CW'(1);
                    else if (!pend_reg)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (is_last)
                    begin
                        loaded_reg <= '0;
                        valid_reg  <= '0;
                        ovf_reg    <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_LOADV;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath for the rank of the current sample
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_GETV:
            begin
                cur_reg  <= rd_val_reg;
                less_reg <= '0;
                eq_reg   <= '0;
                miss_reg <= !rd_fin_reg;
                rank_reg <= rd_fin_reg ? prt_pkg::RANK_HALF : '0;
            end
            S_SCAN:
            begin
                if (pend_reg && rd_fin_reg)
                begin
                    if (rd_val_reg < cur_reg)
                        less_reg <= less_reg + CW'(1);
                    else if (rd_val_reg == cur_reg)
                        eq_reg <= eq_reg + CW'(1);
                end
            end
            S_DIVW:
            begin
                if (div_done)
                    rank_reg <= div_q;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid      = (state_reg == S_EMIT);
    assign rank_fraction     = rank_reg;
    assign missing_sample    = miss_reg;
    assign capacity_overflow = ovf_reg;
    assign last_result       = is_last;

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a ranking run");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_sample) |=> busy)
        else $error("last word did not start a ranking run");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && missing_sample) |-> (rank_fraction == '0))
        else $error("missing sample with nonzero rank");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rank_fraction <= prt_pkg::RANK_ONE))
        else $error("rank above one");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (loaded_reg <= CW'(MAX_SAMPLES)) && (valid_reg <= loaded_reg))
        else $error("sample counts out of range");

endmodule

`default_nettype wire

### src/prt_div.sv
// ----------------------------------------------------------------------------
// prt_div
// Restoring divider, one quotient bit per cycle. Computes
// floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_div #(
    parameter int DW = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DW-1:0]              num,
    input  wire logic [DW-1:0]              den,
    output logic                            done,
    output logic [prt_pkg::RANK_W-1:0]      quotient
);

    localparam int STEPS = prt_pkg::RANK_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DW:0]                   rem_reg;
    logic [DW-1:0]                 den_reg;
    logic [prt_pkg::RANK_W-1:0]    quo_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          run_reg;
    logic                          done_reg;

    logic                          ge;
    logic [DW:0]                   diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[prt_pkg::RANK_W-2:0], ge};
            rem_reg <= {diff[DW-1:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
